// ===== hdl/ptts_pkg.sv =====
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package ptts_pkg;

	localparam int ACTION_W    = 3;
	localparam int SLOT_W      = 6;
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int FIRED_W     = 8;
	localparam int FIRED_SEL_W = $clog2(FIRED_W);

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK        = 3'd0,
		ACT_ADD         = 3'd1,
		ACT_ENABLE      = 3'd2,
		ACT_DELETE      = 3'd3,
		ACT_SET_PERIOD  = 3'd4,
		ACT_RESET_COUNT = 3'd5,
		ACT_READ_PERIOD = 3'd6,
		ACT_READ_COUNT  = 3'd7
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Command word as it walks down the row of slot cells, collecting its result.
	typedef struct packed {
		logic               vld;
		action_t            action;
		logic [SLOT_W-1:0]  slot;
		logic [VALUE_W-1:0] period;
		logic               en;
		logic               claimed;
		status_t            status;
		logic [SLOT_W-1:0]  slot_taken;
		logic [VALUE_W-1:0] read_value;
		logic [FIRED_W-1:0] fired;
	} token_t;

endpackage

// ===== hdl/ptts_cmd_if.sv =====
// Command channel of the tick scheduler: valid/ready plus the command word.
// Depends on ptts_pkg for field widths.
interface ptts_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [ptts_pkg::ACTION_W-1:0] action;
	logic [ptts_pkg::SLOT_W-1:0]   slot;
	logic [ptts_pkg::VALUE_W-1:0]  period_value;
	logic                        enable_flag;

	modport source (output valid, action, slot, period_value, enable_flag, input ready);
	modport sink (input valid, action, slot, period_value, enable_flag, output ready);
endinterface

// ===== hdl/ptts_rsp_if.sv =====
// Response channel of the tick scheduler: valid/ready plus the result word.
// Depends on ptts_pkg for field widths.
interface ptts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ptts_pkg::STATUS_W-1:0] status;
	logic [ptts_pkg::SLOT_W-1:0]   slot_taken;
	logic [ptts_pkg::VALUE_W-1:0]  read_value;
	logic [ptts_pkg::FIRED_W-1:0]  fired_mask;

	modport source (output valid, status, slot_taken, read_value, fired_mask, input ready);
	modport sink (input valid, status, slot_taken, read_value, fired_mask, output ready);
endinterface

// ===== hdl/ptts_cell.sv =====
// One task slot: occupied/enable flags, period and counter, plus the stage
// register that hands the command word to the next slot. Depends on ptts_pkg.
module ptts_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  ptts_pkg::token_t tok_in,
	output ptts_pkg::token_t tok_out
);

	localparam logic [ptts_pkg::SLOT_W-1:0] MY_SLOT = ptts_pkg::SLOT_W'(CELL_IDX);
	localparam logic [ptts_pkg::FIRED_SEL_W-1:0] FIRED_IDX =
		ptts_pkg::FIRED_SEL_W'(CELL_IDX % ptts_pkg::FIRED_W);
	localparam bit HAS_FIRED_BIT = (CELL_IDX < ptts_pkg::FIRED_W);

	logic                         occ_q, occ_d;
	logic                         en_q, en_d;
	logic [ptts_pkg::VALUE_W-1:0] period_q, period_d;
	logic [ptts_pkg::VALUE_W-1:0] cnt_q, cnt_d;
	logic [ptts_pkg::VALUE_W-1:0] cnt_inc;
	logic                         hit;
	ptts_pkg::token_t             tok_q, nxt;

	assign cnt_inc = cnt_q + ptts_pkg::VALUE_W'(1);
	assign hit     = (tok_in.slot == MY_SLOT);

	always_comb begin
		nxt      = tok_in;
		occ_d    = occ_q;
		en_d     = en_q;
		period_d = period_q;
		cnt_d    = cnt_q;
		if (tok_in.vld) begin
			unique case (tok_in.action)
				ptts_pkg::ACT_TICK: begin
					if (occ_q && en_q) begin
						if (cnt_inc == period_q) begin
							cnt_d = '0;
							if (HAS_FIRED_BIT) nxt.fired[FIRED_IDX] = 1'b1;
						end else begin
							cnt_d = cnt_inc;
						end
					end
				end
				ptts_pkg::ACT_ADD: begin
					// first free slot along the row claims the add
					if (!tok_in.claimed && !occ_q) begin
						occ_d          = 1'b1;
						en_d           = 1'b1;
						period_d       = tok_in.period;
						cnt_d          = '0;
						nxt.claimed    = 1'b1;
						nxt.status     = ptts_pkg::ST_OK;
						nxt.slot_taken = MY_SLOT;
					end
				end
				ptts_pkg::ACT_ENABLE: begin
					if (hit) en_d = tok_in.en;
				end
				ptts_pkg::ACT_DELETE: begin
					if (hit) begin
						occ_d    = 1'b0;
						en_d     = 1'b0;
						period_d = '0;
						cnt_d    = '0;
					end
				end
				ptts_pkg::ACT_SET_PERIOD: begin
					if (hit) period_d = tok_in.period;
				end
				ptts_pkg::ACT_RESET_COUNT: begin
					if (hit) cnt_d = '0;
				end
				ptts_pkg::ACT_READ_PERIOD: begin
					if (hit) nxt.read_value = period_q;
				end
				ptts_pkg::ACT_READ_COUNT: begin
					if (hit) nxt.read_value = cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= 1'b0;
			en_q     <= 1'b0;
			period_q <= '0;
			cnt_q    <= '0;
			tok_q    <= '0;
		end else if (adv) begin
			occ_q    <= occ_d;
			en_q     <= en_d;
			period_q <= period_d;
			cnt_q    <= cnt_d;
			tok_q    <= nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hdl/periodic_task_tick_scheduler_unit.sv =====
// An accepted command word goes through the entry register, the slot cells and then
// the output register to its result word; only one word is in flight at a time, and
// it walks the row one cell per cycle unless a full output register holds the row.
// A finished result waits in the output register while the next word is taken.
// Reset (arst_n low) clears every slot: free, disabled, period and counter zero.
// Depends on ptts_pkg, ptts_cmd_if, ptts_rsp_if and ptts_cell.
module periodic_task_tick_scheduler_unit #(
	parameter int SLOT_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ptts_cmd_if.sink    cmd,
	ptts_rsp_if.source  rsp
);

	localparam int CMP_W = ptts_pkg::SLOT_W + 1;

	ptts_pkg::token_t chain [SLOT_COUNT+1];
	ptts_pkg::token_t entry_q;
	logic [SLOT_COUNT:0] vld_vec;

	logic busy_q;
	logic out_valid_q;
	logic [ptts_pkg::STATUS_W-1:0] status_q;
	logic [ptts_pkg::SLOT_W-1:0]   slot_taken_q;
	logic [ptts_pkg::VALUE_W-1:0]  read_value_q;
	logic [ptts_pkg::FIRED_W-1:0]  fired_q;

	logic accept, adv, load_out, out_of_range;
	ptts_pkg::action_t cmd_action;

	assign cmd_action   = ptts_pkg::action_t'(cmd.action);
	assign cmd.ready    = !busy_q;
	assign accept       = cmd.valid && !busy_q;
	// hold the whole row while the last word waits on a full output register
	assign adv          = !(chain[SLOT_COUNT].vld && out_valid_q && !rsp.ready);
	assign load_out     = chain[SLOT_COUNT].vld && adv;
	assign out_of_range = ({1'b0, cmd.slot} >= CMP_W'(SLOT_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (accept) begin
			entry_q.vld        <= 1'b1;
			entry_q.action     <= cmd_action;
			entry_q.slot       <= cmd.slot;
			entry_q.period     <= cmd.period_value;
			entry_q.en         <= cmd.enable_flag;
			entry_q.claimed    <= 1'b0;
			entry_q.slot_taken <= '0;
			entry_q.read_value <= '0;
			entry_q.fired      <= '0;
			if (cmd_action == ptts_pkg::ACT_ADD)
				entry_q.status <= ptts_pkg::ST_FULL;
			else if (cmd_action != ptts_pkg::ACT_TICK && out_of_range)
				entry_q.status <= ptts_pkg::ST_RANGE;
			else
				entry_q.status <= ptts_pkg::ST_OK;
		end else if (adv) begin
			entry_q.vld <= 1'b0;
		end
	end

	assign chain[0]   = entry_q;
	assign vld_vec[0] = chain[0].vld;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		ptts_cell #(.CELL_IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
		assign vld_vec[i+1] = chain[i+1].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) busy_q <= 1'b1;
			else if (load_out) busy_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q     <= chain[SLOT_COUNT].status;
			slot_taken_q <= chain[SLOT_COUNT].slot_taken;
			read_value_q <= chain[SLOT_COUNT].read_value;
			fired_q      <= chain[SLOT_COUNT].fired;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.slot_taken = slot_taken_q;
	assign rsp.read_value = read_value_q;
	assign rsp.fired_mask = fired_q;

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld_vec))
		else $error("more than one command word in the slot row");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (vld_vec == '0))
		else $error("slot row holds a word while not busy");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> entry_q.vld && busy_q)
		else $error("accepted word did not enter the row");

	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> rsp.valid && !busy_q)
		else $error("finished word not moved to output register");

endmodule

// ===== tb/sv/tb_periodic_task_tick_scheduler_unit.sv =====
// Self-checking testbench for periodic_task_tick_scheduler_unit: directed and random commands
// are checked against a predictor of the slot table, with random idling on both channels.
// Depends on ptts_pkg, ptts_cmd_if, ptts_rsp_if and the scheduler RTL.
module tb_periodic_task_tick_scheduler_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS         = 8;
	localparam int SETTLE_CYCLES = SLOTS + 4;
	localparam int IDLE_LIMIT    = 2000;

	typedef struct {
		ptts_pkg::status_t            status;
		logic [ptts_pkg::SLOT_W-1:0]  slot_taken;
		logic [ptts_pkg::VALUE_W-1:0] read_value;
		logic [ptts_pkg::FIRED_W-1:0] fired_mask;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ptts_cmd_if cmd_bus ();
	ptts_rsp_if rsp_bus ();

	periodic_task_tick_scheduler_unit #(
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus.sink),
		.rsp(rsp_bus.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the slot table
	bit                           tbl_occupied [SLOTS];
	bit                           tbl_enabled [SLOTS];
	logic [ptts_pkg::VALUE_W-1:0] tbl_period [SLOTS];
	logic [ptts_pkg::VALUE_W-1:0] tbl_count [SLOTS];

	sched_result_t pending_results [$];
	int unsigned   mismatch_count = 0;
	int unsigned   cmd_gap_pct = 0;
	int unsigned   rsp_stall_pct = 0;
	int unsigned   stall_left = 0;
	int unsigned   idle_cycles = 0;

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Apply one command to the shadow table and return the result it must produce.
	function automatic sched_result_t apply_to_table(ptts_pkg::action_t act,
			logic [ptts_pkg::SLOT_W-1:0] slot, logic [ptts_pkg::VALUE_W-1:0] period, logic en);
		sched_result_t r;
		bit placed;
		r.status     = ptts_pkg::ST_OK;
		r.slot_taken = '0;
		r.read_value = '0;
		r.fired_mask = '0;
		placed       = 1'b0;
		case (act)
			ptts_pkg::ACT_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_occupied[i] && tbl_enabled[i]) begin
						tbl_count[i] = tbl_count[i] + 32'd1;
						if (tbl_count[i] == tbl_period[i]) begin
							tbl_count[i] = '0;
							if (i < ptts_pkg::FIRED_W)
								r.fired_mask[i] = 1'b1;
						end
					end
				end
			end
			ptts_pkg::ACT_ADD: begin
				r.status = ptts_pkg::ST_FULL;
				for (int i = 0; i < SLOTS; i++) begin
					if (!placed && !tbl_occupied[i]) begin
						tbl_occupied[i] = 1'b1;
						tbl_enabled[i]  = 1'b1;
						tbl_period[i]   = period;
						tbl_count[i]    = '0;
						r.status        = ptts_pkg::ST_OK;
						r.slot_taken    = i[ptts_pkg::SLOT_W-1:0];
						placed          = 1'b1;
					end
				end
			end
			default: begin
				if (int'(slot) >= SLOTS) begin
					r.status = ptts_pkg::ST_RANGE;
				end else begin
					case (act)
						ptts_pkg::ACT_ENABLE: tbl_enabled[slot] = en;
						ptts_pkg::ACT_DELETE: begin
							tbl_occupied[slot] = 1'b0;
							tbl_enabled[slot]  = 1'b0;
							tbl_period[slot]   = '0;
							tbl_count[slot]    = '0;
						end
						ptts_pkg::ACT_SET_PERIOD:  tbl_period[slot] = period;
						ptts_pkg::ACT_RESET_COUNT: tbl_count[slot] = '0;
						ptts_pkg::ACT_READ_PERIOD: r.read_value = tbl_period[slot];
						default:                   r.read_value = tbl_count[slot];
					endcase
				end
			end
		endcase
		return r;
	endfunction

	// Present one command word and hold it until taken; valid stays high for a following word.
	task automatic issue_command(ptts_pkg::action_t act, logic [ptts_pkg::SLOT_W-1:0] slot,
			logic [ptts_pkg::VALUE_W-1:0] period, logic en);
		int unsigned gap;
		gap = ($urandom_range(0, 99) < cmd_gap_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid        <= 1'b1;
		cmd_bus.action       <= act;
		cmd_bus.slot         <= slot;
		cmd_bus.period_value <= period;
		cmd_bus.enable_flag  <= en;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		pending_results.push_back(apply_to_table(act, slot, period, en));
	endtask

	task automatic issue_random_command();
		int unsigned                  pick;
		ptts_pkg::action_t            act;
		logic [ptts_pkg::SLOT_W-1:0]  slot;
		logic [ptts_pkg::VALUE_W-1:0] period;
		pick = $urandom_range(0, 99);
		if (pick < 35)      act = ptts_pkg::ACT_TICK;
		else if (pick < 47) act = ptts_pkg::ACT_ADD;
		else if (pick < 55) act = ptts_pkg::ACT_ENABLE;
		else if (pick < 64) act = ptts_pkg::ACT_DELETE;
		else if (pick < 72) act = ptts_pkg::ACT_SET_PERIOD;
		else if (pick < 78) act = ptts_pkg::ACT_RESET_COUNT;
		else if (pick < 88) act = ptts_pkg::ACT_READ_PERIOD;
		else                act = ptts_pkg::ACT_READ_COUNT;
		if ($urandom_range(0, 99) < 85)
			slot = ptts_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
		else
			slot = ptts_pkg::SLOT_W'($urandom_range(0, 63));
		pick = $urandom_range(0, 99);
		// Keep most periods short so slots fire often
		if (pick < 60)      period = $urandom_range(1, 6);
		else if (pick < 68) period = '0;
		else if (pick < 80) period = $urandom_range(7, 40);
		else                period = $urandom();
		issue_command(act, slot, period, $urandom_range(0, 99) < 75);
	endtask

	// Drop valid and hold until every outstanding result has come back.
	task automatic wait_for_results();
		cmd_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		issue_command(ptts_pkg::ACT_READ_PERIOD, 6'd0, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_TICK, 6'd63, 32'hFFFF_FFFF, 1'b1);
		issue_command(ptts_pkg::ACT_ADD, 6'd0, 32'd1, 1'b0);
		issue_command(ptts_pkg::ACT_ADD, 6'd0, 32'd2, 1'b0);
		issue_command(ptts_pkg::ACT_ADD, 6'd63, 32'hFFFF_FFFF, 1'b0);
		issue_command(ptts_pkg::ACT_ADD, 6'd0, 32'd0, 1'b0);
		issue_command(ptts_pkg::ACT_TICK, 6'd0, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_TICK, 6'd0, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_READ_COUNT, 6'd3, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_READ_PERIOD, 6'd2, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_ENABLE, 6'd63, 32'h0, 1'b1);
		issue_command(ptts_pkg::ACT_READ_PERIOD, 6'd8, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_DELETE, 6'd8, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_ENABLE, 6'd0, 32'h0, 1'b0);
		// Enable on a free slot is stored but the slot must stay idle
		issue_command(ptts_pkg::ACT_ENABLE, 6'd7, 32'h0, 1'b1);
		issue_command(ptts_pkg::ACT_TICK, 6'd5, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_READ_COUNT, 6'd7, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_SET_PERIOD, 6'd6, 32'hA5A5_5A5A, 1'b0);
		issue_command(ptts_pkg::ACT_RESET_COUNT, 6'd6, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_READ_PERIOD, 6'd6, 32'h0, 1'b0);
		// Lower a period below the running count: the slot must not fire
		issue_command(ptts_pkg::ACT_SET_PERIOD, 6'd3, 32'd1, 1'b0);
		issue_command(ptts_pkg::ACT_TICK, 6'd0, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_READ_COUNT, 6'd3, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_DELETE, 6'd4, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_RESET_COUNT, 6'd1, 32'h0, 1'b1);
	endtask

	task automatic test_table_full();
		for (int i = 0; i <= SLOTS; i++)
			issue_command(ptts_pkg::ACT_ADD, ptts_pkg::SLOT_W'($urandom_range(0, 63)),
				ptts_pkg::VALUE_W'($urandom_range(1, 4)), 1'b0);
		issue_command(ptts_pkg::ACT_TICK, 6'd0, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_DELETE, 6'd5, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_DELETE, 6'd5, 32'h0, 1'b0);
		issue_command(ptts_pkg::ACT_ADD, 6'd0, 32'd3, 1'b1);
		issue_command(ptts_pkg::ACT_ADD, 6'd0, 32'd3, 1'b1);
		for (int i = 0; i < SLOTS; i++)
			issue_command(ptts_pkg::ACT_DELETE, i[ptts_pkg::SLOT_W-1:0], 32'h0, 1'b0);
	endtask

	task automatic test_random_with_gaps(int unsigned count);
		cmd_gap_pct   = 30;
		rsp_stall_pct = 30;
		for (int unsigned n = 0; n < count; n++) begin
			issue_random_command();
			if (n % 150 == 149)
				wait_for_results();
		end
	endtask

	task automatic test_back_to_back(int unsigned count);
		cmd_gap_pct   = 0;
		rsp_stall_pct = 0;
		repeat (count) issue_random_command();
	endtask

	task automatic test_heavy_stall(int unsigned count);
		cmd_gap_pct   = 15;
		rsp_stall_pct = 60;
		repeat (count) issue_random_command();
	endtask

	// Response side: random stall lengths, most short
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
				if ($urandom_range(0, 99) < rsp_stall_pct)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		sched_result_t exp_r;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no command outstanding");
				mismatch_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_bus.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, rsp_bus.status);
					mismatch_count++;
				end
				if (rsp_bus.slot_taken !== exp_r.slot_taken) begin
					$error("slot_taken: expected %0d, got %0d", exp_r.slot_taken,
						rsp_bus.slot_taken);
					mismatch_count++;
				end
				if (rsp_bus.read_value !== exp_r.read_value) begin
					$error("read_value: expected 0x%08h, got 0x%08h", exp_r.read_value,
						rsp_bus.read_value);
					mismatch_count++;
				end
				if (rsp_bus.fired_mask !== exp_r.fired_mask) begin
					$error("fired_mask: expected 0x%02h, got 0x%02h", exp_r.fired_mask,
						rsp_bus.fired_mask);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n               = 1'b0;
		cmd_bus.valid        = 1'b0;
		cmd_bus.action       = ptts_pkg::ACT_TICK;
		cmd_bus.slot         = '0;
		cmd_bus.period_value = '0;
		cmd_bus.enable_flag  = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_occupied[i] = 1'b0;
			tbl_enabled[i]  = 1'b0;
			tbl_period[i]   = '0;
			tbl_count[i]    = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_table_full();
		test_random_with_gaps(600);
		test_back_to_back(400);
		test_heavy_stall(900);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== periodic_task_tick_scheduler_unit.f =====
hdl/ptts_pkg.sv
hdl/ptts_cmd_if.sv
hdl/ptts_rsp_if.sv
hdl/ptts_cell.sv
hdl/periodic_task_tick_scheduler_unit.sv
tb/sv/tb_periodic_task_tick_scheduler_unit.sv
